FILE: rtl/core/pgm_pkg.sv
// Shared constants and types for the path glob matcher.
// No dependencies; used by pgm_cell and path_glob_matcher.
`timescale 1ns / 1ps
`default_nettype none
package pgm_pkg;

   localparam int PATTERN_MAX_DEFAULT = 32;
   localparam int STORED_CHARS        = 32;
   localparam int LENGTH_W            = 6;
   localparam int WORD_W              = 64;
   localparam int WORD_COUNT          = 4;
   localparam int CSR_INDEX_W         = 3;

   localparam logic [7:0] CHAR_STAR      = 8'h2A;
   localparam logic [7:0] CHAR_QMARK     = 8'h3F;
   localparam logic [7:0] CHAR_SLASH     = 8'h2F;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

   localparam logic [CSR_INDEX_W-1:0] CSR_LENGTH = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WORD_0 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WORD_1 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WORD_2 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WORD_3 = 3'd4;

   // broadcast to every cell
   typedef struct packed {
      logic       step;
      logic       restart;
      logic       sep;
      logic [7:0] ch;
   } ctrl_type;

   // handed from one cell to the next
   typedef struct packed {
      logic reach;
      logic link;
      logic adv;
   } cell_out_type;

endpackage
`default_nettype wire

FILE: rtl/core/pgm_cell.sv
// One pattern position of the glob automaton: active bit, star closure, advance.
// Depends on pgm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pgm_cell (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   home,
   input  wire pgm_pkg::ctrl_type ctrl,
   input  wire [7:0]             pat_char,
   input  wire                   in_range,
   input  wire                   link_in,
   input  wire                   adv_in,
   output pgm_pkg::cell_out_type cell_out
);

   logic active_ff;
   logic active_in;
   logic reach;
   logic is_star;
   logic is_any;
   logic consume;

   assign reach   = active_ff | link_in;
   assign is_star = (pat_char == pgm_pkg::CHAR_STAR);
   assign is_any  = (pat_char == pgm_pkg::CHAR_QMARK);
   assign consume = is_any ? ~ctrl.sep : (ctrl.ch == pat_char);

   assign cell_out.reach = reach;
   assign cell_out.link  = reach & in_range & is_star;
   assign cell_out.adv   = reach & in_range & ~is_star & consume;

   always_comb begin
      if (ctrl.restart) begin
         active_in = home;
      end else if (ctrl.step) begin
         active_in = (reach & in_range & is_star & ~ctrl.sep) | adv_in;
      end else begin
         active_in = active_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= home;
      end else begin
         active_ff <= active_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/path_glob_matcher.sv
// Path glob matcher top level: config registers, chain of pattern cells, result register.
// Depends on pgm_pkg and pgm_cell.
//
// Usage:
//   csr_*  : write channel; csr_index 0 is the pattern length, 1..4 the pattern
//            words (8 chars each, char i in bits 8*i up). Always ready.
//   req_*  : one name character per beat; tlast marks the last character,
//            tuser marks a beat with no character (an empty name with tlast; tdata ignored).
//   rsp_*  : one beat per name, tdata bit 0 = matched.
// Flow: non-last characters are taken back to back. A last beat sets pending, which
//   holds req_tready low: the cell chain is stepped in the accept cycle, and once the
//   result register is free the same chain's star closure evaluates the final active set.
//   Closure ripples through up to PATTERN_MAX cells combinationally.
// Result: the last beat sets pending_ff; the match is then registered to rsp_tvalid once out_free.
// Stall: characters keep flowing while a result waits in the result register.
//   A following last beat is held in the chain and req_tready stays low until
//   rsp_tready frees the result register.
// Reset: synchronous; registers clear to zero, active set to position 0.
`timescale 1ns / 1ps
`default_nettype none
module path_glob_matcher #(
   parameter int PATTERN_MAX = pgm_pkg::PATTERN_MAX_DEFAULT
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            csr_valid,
   output logic                           csr_ready,
   input  wire [pgm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire [pgm_pkg::WORD_W-1:0]      csr_data,
   input  wire                            req_tvalid,
   output logic                           req_tready,
   input  wire [7:0]                      req_tdata,   // [7:0] ch
   input  wire                            req_tlast,   // is_last
   input  wire                            req_tuser,   // [0] no_char
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready,
   output logic [7:0]                     rsp_tdata    // [0] matched, [7:1] zero
);

   localparam int LEN_W = $clog2(PATTERN_MAX + 1);
   localparam int PAT_W = pgm_pkg::WORD_W * pgm_pkg::WORD_COUNT;
   localparam logic [6:0] MAX7 = 7'(PATTERN_MAX);

   logic [pgm_pkg::LENGTH_W-1:0] length_ff;
   logic [PAT_W-1:0]             pattern_ff;
   logic                         pending_ff;
   logic                         rsp_valid_ff;
   logic                         matched_ff;

   logic [6:0]                   eff7;
   logic [LEN_W-1:0]             eff_len;
   logic                         req_fire;
   logic                         csr_fire;
   logic                         out_free;
   pgm_pkg::ctrl_type            ctrl;
   pgm_pkg::cell_out_type        cell_out [0:PATTERN_MAX];
   logic [PATTERN_MAX:0]         reach_vec;

   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid & csr_ready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign req_tready = ~pending_ff;
   assign req_fire   = req_tvalid & req_tready;

   assign eff7    = ({1'b0, length_ff} > MAX7) ? MAX7 : {1'b0, length_ff};
   assign eff_len = LEN_W'(eff7);

   assign ctrl.step    = req_fire & ~req_tuser;
   assign ctrl.restart = pending_ff & out_free;
   assign ctrl.ch      = req_tdata;
   assign ctrl.sep     = (req_tdata == pgm_pkg::CHAR_SLASH) |
                         (req_tdata == pgm_pkg::CHAR_BACKSLASH);

   genvar gi;
   generate
      for (gi = 0; gi <= PATTERN_MAX; gi++) begin : g_cell
         logic [7:0] pat_char;
         logic       link_in;
         logic       adv_in;

         if (gi < pgm_pkg::STORED_CHARS) begin : g_stored
            assign pat_char = pattern_ff[8*gi +: 8];
         end else begin : g_blank
            assign pat_char = 8'h00;
         end

         if (gi == 0) begin : g_head
            assign link_in = 1'b0;
            assign adv_in  = ctrl.sep;
         end else begin : g_body
            assign link_in = cell_out[gi-1].link;
            assign adv_in  = cell_out[gi-1].adv;
         end

         pgm_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .home     (gi == 0),
            .ctrl     (ctrl),
            .pat_char (pat_char),
            .in_range (eff7 > 7'(gi)),
            .link_in  (link_in),
            .adv_in   (adv_in),
            .cell_out (cell_out[gi])
         );

         assign reach_vec[gi] = cell_out[gi].reach;
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff  <= '0;
         pattern_ff <= '0;
      end else if (csr_fire) begin
         unique case (csr_index)
            pgm_pkg::CSR_LENGTH: length_ff <= csr_data[pgm_pkg::LENGTH_W-1:0];
            pgm_pkg::CSR_WORD_0: pattern_ff[0*pgm_pkg::WORD_W +: pgm_pkg::WORD_W] <= csr_data;
            pgm_pkg::CSR_WORD_1: pattern_ff[1*pgm_pkg::WORD_W +: pgm_pkg::WORD_W] <= csr_data;
            pgm_pkg::CSR_WORD_2: pattern_ff[2*pgm_pkg::WORD_W +: pgm_pkg::WORD_W] <= csr_data;
            pgm_pkg::CSR_WORD_3: pattern_ff[3*pgm_pkg::WORD_W +: pgm_pkg::WORD_W] <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         matched_ff   <= 1'b0;
      end else begin
         if (pending_ff) begin
            if (out_free) begin
               pending_ff <= 1'b0;
            end
         end else if (req_fire && req_tlast) begin
            pending_ff <= 1'b1;
         end
         if (pending_ff && out_free) begin
            rsp_valid_ff <= 1'b1;
            matched_ff   <= reach_vec[eff_len];
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, matched_ff};

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking bench for path_glob_matcher: drives name bytes, pattern writes and
// result back-pressure, and checks every match result against its own automaton model.
// Depends on pgm_pkg and the path_glob_matcher RTL.
`timescale 1ns / 1ps
module tb_top;
   import pgm_pkg::*;

   localparam int MATCH_LIMIT = PATTERN_MAX_DEFAULT;
   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 120;
   localparam int PHASES      = 14;
   localparam int PHASE_ITEMS = 100;

   class match_scoreboard;
      bit [LENGTH_W-1:0]    len_reg;
      bit [WORD_W-1:0]      words [WORD_COUNT];
      bit [MATCH_LIMIT:0]   live;
      bit                   expected_matches [$];
      int                   failures;

      function new();
         live = 1;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [WORD_W-1:0] val);
         case (idx)
            CSR_LENGTH: len_reg = val[LENGTH_W-1:0];
            CSR_WORD_0: words[0] = val;
            CSR_WORD_1: words[1] = val;
            CSR_WORD_2: words[2] = val;
            CSR_WORD_3: words[3] = val;
            default: ;
         endcase
      endfunction

      function int eff_len();
         return (len_reg > MATCH_LIMIT) ? MATCH_LIMIT : int'(len_reg);
      endfunction

      function bit [7:0] pat_char(int idx);
         if (idx >= STORED_CHARS) return 8'h00;
         return words[idx / 8][(idx % 8) * 8 +: 8];
      endfunction

      function bit is_sep(logic [7:0] c);
         return c == CHAR_SLASH || c == CHAR_BACKSLASH;
      endfunction

      function void step_set(logic [7:0] c);
         bit [MATCH_LIMIT:0] nxt;
         int                 pos;
         int                 len;
         bit                 busy;
         bit                 sep;
         bit [7:0]           p;
         len = eff_len();
         sep = is_sep(c);
         nxt = '0;
         if (sep) nxt[0] = 1'b1;
         for (int s = 0; s <= MATCH_LIMIT; s++) begin
            if (!live[s]) continue;
            pos  = s;
            busy = 1'b1;
            while (busy && pos < len) begin
               p = pat_char(pos);
               if (p == CHAR_STAR) begin
                  if (!sep) nxt[pos] = 1'b1;
                  pos++;
               end else begin
                  if (p == CHAR_QMARK) begin
                     if (!sep) nxt[pos + 1] = 1'b1;
                  end else if (c == p) begin
                     nxt[pos + 1] = 1'b1;
                  end
                  busy = 1'b0;
               end
            end
         end
         live = nxt;
      endfunction

      function bit final_match();
         int q;
         int len;
         len = eff_len();
         for (int s = 0; s <= MATCH_LIMIT; s++) begin
            if (!live[s]) continue;
            q = s;
            while (q < len && pat_char(q) == CHAR_STAR) q++;
            if (q == len) return 1'b1;
         end
         return 1'b0;
      endfunction

      function void note_beat(logic [7:0] c, logic last, logic empty);
         if (!empty) step_set(c);
         if (last) begin
            expected_matches.push_back(final_match());
            live = 1;
         end
      endfunction

      function void report(string what, logic [7:0] exp_v, logic [7:0] got_v);
         failures++;
         if (failures <= 10)
            $display("%0t: %s: expected matched=%0d tdata=%h, got tdata=%h",
                     $realtime, what, exp_v[0], exp_v, got_v);
      endfunction

      function void check_result(logic [7:0] got);
         logic [7:0] exp_v;
         if (expected_matches.size() == 0) begin
            report("result with no name pending", 8'h00, got);
            return;
         end
         exp_v = {7'd0, expected_matches.pop_front()};
         if (got !== exp_v) report("match result differs", exp_v, got);
      endfunction
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   csr_valid  = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [WORD_W-1:0]      csr_data   = '0;
   logic                   req_tvalid = 1'b0;
   logic [7:0]             req_tdata  = '0;
   logic                   req_tlast  = 1'b0;
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tready = 1'b0;
   wire                    csr_ready;
   wire                    req_tready;
   wire                    rsp_tvalid;
   wire  [7:0]             rsp_tdata;

   match_scoreboard sb = new();

   logic [7:0] pat_buf [STORED_CHARS];
   logic [7:0] name_q [$];
   bit         idle_on  = 1'b1;
   bit         hold_req = 1'b0;
   int         items    = 0;
   int         quiet    = 0;

   path_glob_matcher DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] ch
      .req_tlast  (req_tlast),   // is_last
      .req_tuser  (req_tuser),   // [0] no_char
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)    // [0] matched, [7:1] zero
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet = 0;
      else
         quiet++;
      if (quiet >= QUIET_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // result side: random stall bursts plus one long hold-off
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if (hold_req) begin
            stall    = HOLD_CYCLES;
            hold_req = 1'b0;
         end
         if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 6) == 0) begin
            stall = $urandom_range(1, 14) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, logic [WORD_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
   endtask

   function automatic logic [WORD_W-1:0] word_of(int w);
      logic [WORD_W-1:0] r;
      for (int k = 0; k < 8; k++) r[k * 8 +: 8] = pat_buf[w * 8 + k];
      return r;
   endfunction

   task automatic load_pattern(int raw_len);
      csr_write(CSR_LENGTH, WORD_W'(raw_len));
      csr_write(CSR_WORD_0, word_of(0));
      csr_write(CSR_WORD_1, word_of(1));
      csr_write(CSR_WORD_2, word_of(2));
      csr_write(CSR_WORD_3, word_of(3));
      csr_valid <= 1'b0;
   endtask

   task automatic push_beat(logic [7:0] c, logic last, logic empty);
      int gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 14);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      req_tuser  <= empty;
      do @(posedge clock); while (!req_tready);
      sb.note_beat(c, last, empty);
   endtask

   // no result outstanding and the chain given time to settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.expected_matches.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_name();
      if (name_q.size() == 0) begin
         push_beat(8'($urandom), 1'b1, 1'b1);
         items++;
      end else begin
         foreach (name_q[i]) begin
            if ($urandom_range(0, 11) == 0) push_beat(8'($urandom), 1'b0, 1'b1);
            push_beat(name_q[i], i == name_q.size() - 1, 1'b0);
            items++;
         end
      end
   endtask

   task automatic text_name(string s);
      name_q.delete();
      for (int i = 0; i < s.len(); i++) name_q.push_back(s[i]);
      send_name();
   endtask

   task automatic text_pattern(string s);
      foreach (pat_buf[i]) pat_buf[i] = (i < s.len()) ? s[i] : 8'h00;
      load_pattern(s.len());
   endtask

   function automatic logic [7:0] pick_plain();
      logic [7:0] c;
      case ($urandom_range(0, 3))
         0: c = "a";
         1: c = "b";
         2: c = "c";
         default: c = 8'($urandom);
      endcase
      if (c == CHAR_SLASH || c == CHAR_BACKSLASH) c = "a";
      return c;
   endfunction

   function automatic logic [7:0] pick_any();
      case ($urandom_range(0, 7))
         0: return "a";
         1: return "b";
         2: return "c";
         3: return CHAR_STAR;
         4: return CHAR_QMARK;
         5: return CHAR_SLASH;
         6: return CHAR_BACKSLASH;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic build_name(int len);
      name_q.delete();
      if ($urandom_range(0, 9) < 7) begin
         if ($urandom_range(0, 3) == 0) begin
            name_q.push_back(pick_plain());
            name_q.push_back($urandom_range(0, 1) ? CHAR_SLASH : CHAR_BACKSLASH);
         end
         for (int i = 0; i < len; i++) begin
            if (pat_buf[i] == CHAR_STAR)
               repeat ($urandom_range(0, 3)) name_q.push_back(pick_plain());
            else if (pat_buf[i] == CHAR_QMARK)
               name_q.push_back(pick_plain());
            else
               name_q.push_back(pat_buf[i]);
         end
         if (name_q.size() > 0 && $urandom_range(0, 4) == 0)
            name_q[$urandom_range(0, name_q.size() - 1)] = pick_any();
      end else begin
         repeat ($urandom_range(0, 8)) name_q.push_back(pick_any());
      end
   endtask

   initial begin
      int raw_len;
      int len;
      int goal;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset pattern: length zero
      push_beat(8'hFF, 1'b1, 1'b1);
      push_beat(8'h00, 1'b1, 1'b0);
      push_beat(CHAR_SLASH, 1'b1, 1'b0);
      push_beat(8'hFF, 1'b0, 1'b0);
      push_beat(8'h5A, 1'b0, 1'b1);
      push_beat(CHAR_BACKSLASH, 1'b1, 1'b0);
      drain();

      text_pattern("a?b*");
      text_name("axb");
      text_name("a/b");
      text_name("d/axbq");
      text_name("\\axb");
      drain();

      // pattern rewritten in the middle of a name keeps the active set
      text_pattern("ab");
      push_beat("a", 1'b0, 1'b0);
      drain();
      text_pattern("zb");
      push_beat("b", 1'b1, 1'b0);
      drain();

      // length beyond the bound, all stars
      foreach (pat_buf[i]) pat_buf[i] = CHAR_STAR;
      load_pattern(63);
      push_beat("q", 1'b1, 1'b0);
      push_beat(8'h00, 1'b1, 1'b1);
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         idle_on = (ph < PHASES - 2) && ($urandom_range(0, 4) != 0);
         foreach (pat_buf[i]) pat_buf[i] = pick_any();
         case (ph)
            0: raw_len = STORED_CHARS;
            1: raw_len = 63;
            2: begin
               foreach (pat_buf[i]) pat_buf[i] = 8'hFF;
               raw_len = STORED_CHARS;
            end
            3: begin
               foreach (pat_buf[i]) pat_buf[i] = 8'h00;
               raw_len = 0;
            end
            4: raw_len = $urandom_range(33, 62);
            default: raw_len = $urandom_range(1, 10);
         endcase
         load_pattern(raw_len);
         len = (raw_len > MATCH_LIMIT) ? MATCH_LIMIT : raw_len;
         if (ph == 0) hold_req = 1'b1;
         goal = items + PHASE_ITEMS;
         while (items < goal) begin
            build_name(len);
            send_name();
         end
         drain();
      end

      repeat (10) @(posedge clock);
      if (sb.failures == 0 && sb.expected_matches.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
